// ===== rtl/core/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

    localparam int DATA_W     = 32;
    localparam int CAP_W      = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } rsp_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/lkvc_match.sv =====
`default_nettype none

module lkvc_match #(
    parameter int ENTRIES = 16,
    parameter int RANK_W  = 4
) (
    input  wire logic [ENTRIES-1:0]                           valid,
    input  wire logic [ENTRIES-1:0][lkvc_pkg::DATA_W-1:0]     keys,
    input  wire logic [ENTRIES-1:0][lkvc_pkg::DATA_W-1:0]     values,
    input  wire logic [ENTRIES-1:0][RANK_W-1:0]               ranks,
    input  wire logic [lkvc_pkg::DATA_W-1:0]                  key,
    output logic      [ENTRIES-1:0]                           hit_oh,
    output logic                                              hit,
    output logic      [lkvc_pkg::DATA_W-1:0]                  hit_value,
    output logic      [RANK_W-1:0]                            hit_rank
);
    import lkvc_pkg::*;

    // Valid keys are unique, so at most one compare fires: select by OR.
    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_oh[i] = valid[i] && (keys[i] == key);
            hit_value = hit_value | (values[i] & {DATA_W{hit_oh[i]}});
            hit_rank  = hit_rank | (ranks[i] & {RANK_W{hit_oh[i]}});
        end
        hit = |hit_oh;
    end

endmodule

`default_nettype wire

// ===== rtl/core/lkvc_update.sv =====
`default_nettype none

module lkvc_update #(
    parameter int ENTRIES = 16,
    parameter int RANK_W  = 4,
    parameter int ECAP_W  = 5
) (
    input  wire logic                            op,
    input  wire logic                            hit,
    input  wire logic [ENTRIES-1:0]              hit_oh,
    input  wire logic [RANK_W-1:0]               hit_rank,
    input  wire logic [ECAP_W-1:0]               eff_cap,
    input  wire logic [ENTRIES-1:0]              valid,
    input  wire logic [ENTRIES-1:0][RANK_W-1:0]  ranks,
    output logic      [ENTRIES-1:0]              valid_next,
    output logic      [ENTRIES-1:0][RANK_W-1:0]  ranks_next,
    output logic      [ENTRIES-1:0]              write_oh
);
    import lkvc_pkg::*;

    logic [ENTRIES-1:0] evict;
    logic [ENTRIES-1:0] kept;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0][RANK_W-1:0] ranks_inc;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            ranks_inc[i] = RANK_W'(ranks[i] + 1'b1);
            evict[i]     = valid[i]
                           && ((ECAP_W'(ranks[i]) + ECAP_W'(1)) >= eff_cap);
        end
        kept    = valid & ~evict;
        // Lowest free slot after eviction
        free_oh = ~kept & (kept + ENTRIES'(1));
    end

    always_comb
    begin
        valid_next = valid;
        ranks_next = ranks;
        write_oh   = '0;
        if (hit)
        begin
            // Age everything younger than the hit entry, then make it newest
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (hit_oh[i])
                    ranks_next[i] = '0;
                else if (valid[i] && (ranks[i] < hit_rank))
                    ranks_next[i] = ranks_inc[i];
            end
            if (op == OP_PUT)
                write_oh = hit_oh;
        end
        else if (op == OP_PUT)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (kept[i])
                    ranks_next[i] = ranks_inc[i];
                else if (free_oh[i])
                    ranks_next[i] = '0;
            end
            valid_next = kept | free_oh;
            write_oh   = free_oh;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache_core.sv =====
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// A request item is a get (op 0) or a put (op 1) of a 32-bit key; keys match
// as raw bit patterns. Every get yields one response item: hit 1 and the
// stored value, or hit 0 and -1 on a miss. Puts yield no response. A put of
// a new key evicts every entry whose age would reach the capacity register
// (effective range 1 to ENTRIES; 0 acts as 1, larger values saturate) and
// takes the lowest free slot; lowering the capacity evicts nothing until the
// next insertion. The block takes one item per cycle: each item sits in the
// request register while a single pass of parallel tag compare and age
// update rewrites the entry flops; each get's answer is loaded into the
// response register. Only a get whose response cannot leave (response
// register full and stalled) holds the request side. The store is empty
// after reset and ready at once. Capacity sits at APB byte address 0.
module lru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire lkvc_pkg::req_item_t             req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output lkvc_pkg::rsp_item_t                  rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lkvc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lkvc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [lkvc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import lkvc_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENT_W  = $clog2(ENTRIES + 1);
    localparam int W0     = (ENT_W > CAP_W) ? ENT_W : CAP_W;
    localparam int ECAP_W = (W0 > RANK_W + 1) ? W0 : RANK_W + 1;

    // Configuration
    logic [CAP_W-1:0]  capacity_reg;
    logic [ECAP_W-1:0] eff_cap;
    logic              cfg_write;

    // Request and response registers
    logic      req_valid_reg;
    req_item_t req_reg;
    logic      rsp_valid_reg;
    rsp_item_t rsp_reg;
    logic      fire;
    logic      accept;

    // Entry store
    logic [ENTRIES-1:0]               valid_reg;
    logic [ENTRIES-1:0][RANK_W-1:0]   ranks_reg;
    logic [ENTRIES-1:0][DATA_W-1:0]   keys_reg;
    logic [ENTRIES-1:0][DATA_W-1:0]   values_reg;
    logic [ENTRIES-1:0]               valid_next;
    logic [ENTRIES-1:0][RANK_W-1:0]   ranks_next;
    logic [ENTRIES-1:0]               write_oh;

    logic [ENTRIES-1:0] hit_oh;
    logic               hit;
    logic [DATA_W-1:0]  hit_value;
    logic [RANK_W-1:0]  hit_rank;

    // APB: always ready, register written on the access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY)
                       ? APB_DATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAPACITY_RESET;
        else if (cfg_write)
            capacity_reg <= pwdata[CAP_W-1:0];
    end

    // Clamp capacity to 1..ENTRIES
    always_comb
    begin
        if (capacity_reg == '0)
            eff_cap = ECAP_W'(1);
        else if (ECAP_W'(capacity_reg) > ECAP_W'(ENTRIES))
            eff_cap = ECAP_W'(ENTRIES);
        else
            eff_cap = ECAP_W'(capacity_reg);
    end

    // Process the held item unless it is a get facing a blocked response
    assign fire      = req_valid_reg
                       && ((req_reg.op == OP_PUT) || !rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !fire;
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (accept)
            req_valid_reg <= 1'b1;
        else if (fire)
            req_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req;
    end

    lkvc_match #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W)
    ) u_match (
        .valid     (valid_reg),
        .keys      (keys_reg),
        .values    (values_reg),
        .ranks     (ranks_reg),
        .key       (req_reg.key),
        .hit_oh    (hit_oh),
        .hit       (hit),
        .hit_value (hit_value),
        .hit_rank  (hit_rank)
    );

    lkvc_update #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .ECAP_W  (ECAP_W)
    ) u_update (
        .op         (req_reg.op),
        .hit        (hit),
        .hit_oh     (hit_oh),
        .hit_rank   (hit_rank),
        .eff_cap    (eff_cap),
        .valid      (valid_reg),
        .ranks      (ranks_reg),
        .valid_next (valid_next),
        .ranks_next (ranks_next),
        .write_oh   (write_oh)
    );

    // Commit the update when the item fires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ranks_reg <= '0;
        end
        else if (fire)
        begin
            valid_reg <= valid_next;
            ranks_reg <= ranks_next;
        end
    end

    // Key and value payload: written by puts only, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (fire && write_oh[i])
            begin
                keys_reg[i]   <= req_reg.key;
                values_reg[i] <= req_reg.value;
            end
        end
    end

    // Response register: load on a get, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (fire && (req_reg.op == OP_GET))
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && (req_reg.op == OP_GET))
        begin
            rsp_reg.hit        <= hit;
            rsp_reg.read_value <= hit ? hit_value : MISS_VALUE;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== bench/tb_lru_key_value_cache_core.sv =====
`default_nettype none

module tb_lru_key_value_cache_core;

    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int SLOTS = 16;

    // Shadow copy of the cache. It tracks keys, values, valid flags and age
    // ranks, and queues the response that each get has to produce.
    class lru_shadow;
        logic [DATA_W-1:0] slot_key   [SLOTS];
        logic [DATA_W-1:0] slot_value [SLOTS];
        bit                slot_used  [SLOTS];
        int unsigned       slot_age   [SLOTS];
        int unsigned       used_count;
        logic [CAP_W-1:0]  capacity;
        rsp_item_t         reads_due [$];
        int                errors;
        int                n_gets;
        int                n_hits;
        int                n_puts;
        int                n_evicted;

        function new();
            foreach (slot_used[i])
            begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_used[i]  = 1'b0;
                slot_age[i]   = 0;
            end
            used_count = 0;
            capacity   = CAPACITY_RESET;
            errors     = 0;
            n_gets     = 0;
            n_hits     = 0;
            n_puts     = 0;
            n_evicted  = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return reads_due.size();
        endfunction

        // Age every younger entry by one and make this slot the newest.
        function void promote(int slot);
            int unsigned old_age;
            old_age = slot_age[slot];
            foreach (slot_used[i])
                if (slot_used[i] && slot_age[i] < old_age)
                    slot_age[i]++;
            slot_age[slot] = 0;
        endfunction

        function void apply_request(req_item_t item);
            int          slot;
            int          free_slot;
            int unsigned limit;
            int unsigned kept;
            rsp_item_t   answer;
            slot = -1;
            foreach (slot_used[i])
                if (slot == -1 && slot_used[i] && slot_key[i] == item.key)
                    slot = i;
            if (item.op == OP_GET)
            begin
                n_gets++;
                if (slot >= 0)
                begin
                    n_hits++;
                    promote(slot);
                    answer.hit        = 1'b1;
                    answer.read_value = slot_value[slot];
                end
                else
                begin
                    answer.hit        = 1'b0;
                    answer.read_value = MISS_VALUE;
                end
                reads_due.push_back(answer);
                return;
            end
            n_puts++;
            if (slot >= 0)
            begin
                slot_value[slot] = item.value;
                promote(slot);
                return;
            end
            // New key: clamp the capacity, drop whatever would age out, then
            // take the lowest free slot.
            limit = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : capacity);
            foreach (slot_used[i])
                if (slot_used[i] && slot_age[i] + 1 >= limit)
                begin
                    slot_used[i] = 1'b0;
                    n_evicted++;
                end
            free_slot = -1;
            kept      = 0;
            foreach (slot_used[i])
                if (slot_used[i])
                begin
                    slot_age[i]++;
                    kept++;
                end
                else if (free_slot < 0)
                    free_slot = i;
            used_count = kept;
            if (free_slot < 0)
                return;
            slot_key[free_slot]   = item.key;
            slot_value[free_slot] = item.value;
            slot_used[free_slot]  = 1'b1;
            slot_age[free_slot]   = 0;
            used_count            = kept + 1;
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (reads_due.size() == 0)
            begin
                $error("response with no get outstanding: hit %0d read_value %h",
                       got.hit, got.read_value);
                errors++;
                return;
            end
            want = reads_due.pop_front();
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                errors++;
            end
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_item_t             rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lru_shadow board = new();

    // Handshake knobs shared between the request driver and the response side.
    bit rsp_quiet    = 1'b0;  // no response stalls during back-to-back stretches
    bit hold_request = 1'b0;  // ask the response side for one long hold-off
    int cap_writes   = 0;

    // Capacity for each random phase: full size, the clamped extremes (0 and
    // values above the store size), and drops below the current fill level.
    int capacity_plan [12] = '{16, 1, 0, 31, 5, 3, 16, 9, 2, 20, 17, 7};

    lru_key_value_cache_core #(
        .ENTRIES(SLOTS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic req_item_t make_item(logic op, logic [DATA_W-1:0] k,
                                            logic [DATA_W-1:0] v);
        req_item_t item;
        item.op    = op;
        item.key   = k;
        item.value = v;
        return item;
    endfunction

    // Offer one item. Valid stays high from the previous item when no gap is
    // drawn, so back-to-back items never drop valid within a time step.
    // Return at the edge where the item was accepted.
    task automatic send_item(input req_item_t item, input bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        // Inputs are sampled before any update of this edge, so req_stall
        // here is the value the block saw at the edge.
        do @(posedge clk); while (req_stall);
        board.apply_request(item);
    endtask

    task automatic put_item(input logic [DATA_W-1:0] k, input logic [DATA_W-1:0] v);
        send_item(make_item(OP_PUT, k, v), 1'b0);
    endtask

    task automatic get_item(input logic [DATA_W-1:0] k);
        send_item(make_item(OP_GET, k, $urandom), 1'b0);
    endtask

    // Drop valid and wait for every outstanding get to answer, then give a
    // trailing put time to pass the two-stage pipeline.
    task automatic settle();
        req_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, done at the edge with pready high.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_capacity(value);
        cap_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Response side: draw a stall length for every response taken, and honor
    // one long hold-off on request so the block backs up into its input.
    initial
    begin : response_side
        int unsigned wait_left;
        int unsigned hold_left;
        wait_left = 0;
        hold_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && !rsp_stall)
            begin
                board.check_response(rsp);
                wait_left = rsp_quiet ? 0 : $urandom_range(0, 18);
            end
            if (hold_request)
            begin
                hold_left    = 80;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (wait_left != 0)
            begin
                wait_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        logic [DATA_W-1:0] key_pool [$];
        logic [DATA_W-1:0] k;
        int unsigned       limit;
        int unsigned       pool_size;
        logic              op;
        bit                quiet;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store, key and value extremes, overwrite of a present key.
        // A stored -1 must come back with hit set, unlike a miss.
        get_item(32'h0000_0000);
        put_item(32'h8000_0000, 32'h7FFF_FFFF);
        put_item(32'h7FFF_FFFF, 32'h8000_0000);
        put_item(32'h0000_0000, 32'h0000_0000);
        put_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        get_item(32'h8000_0000);
        get_item(32'h7FFF_FFFF);
        get_item(32'h0000_0000);
        get_item(32'hFFFF_FFFF);
        put_item(32'h0000_0000, 32'h1234_5678);
        get_item(32'h0000_0000);
        settle();

        // Capacity two with four entries present: a new key clears several
        // entries at once, then plain LRU eviction with a refreshed entry.
        write_capacity(5'd2);
        put_item(32'h0000_000A, 32'h0000_0001);
        put_item(32'h0000_000B, 32'h0000_0002);
        get_item(32'h0000_000A);
        put_item(32'h0000_000C, 32'h0000_0003);
        get_item(32'h0000_000B);
        get_item(32'h0000_000A);
        get_item(32'h0000_000C);
        settle();

        // Lower the capacity under the fill level: old entries still hit
        // until the next insertion trims the store.
        write_capacity(5'd16);
        for (int i = 0; i < 6; i++)
            put_item(32'h0000_0100 + i, $urandom);
        settle();
        write_capacity(5'd3);
        get_item(32'h0000_0100);
        put_item(32'h0000_0200, 32'hDEAD_BEEF);
        get_item(32'h0000_0101);
        get_item(32'h0000_0200);
        settle();

        // Random phases. Most keys come from a small pool sized to the
        // capacity so hits, updates and evictions all happen; the rest are
        // fresh random keys.
        for (int p = 0; p < 12; p++)
        begin
            write_capacity(capacity_plan[p][CAP_W-1:0]);
            limit = (capacity_plan[p] == 0) ? 1 :
                    ((capacity_plan[p] > SLOTS) ? SLOTS : capacity_plan[p]);
            pool_size = limit + 3;
            key_pool.delete();
            for (int i = 0; i < pool_size; i++)
                key_pool.push_back($urandom);
            quiet     = (p % 4 == 2);
            rsp_quiet = quiet;

            if (p == 6)
            begin
                // Hold the response side off while gets keep coming back to
                // back, so the response register fills and the input stalls.
                hold_request = 1'b1;
                for (int i = 0; i < 30; i++)
                    send_item(make_item(OP_GET,
                              key_pool[$urandom_range(0, pool_size - 1)], $urandom), 1'b1);
            end

            for (int n = 0; n < 54; n++)
            begin
                k  = ($urandom_range(0, 99) < 85) ?
                     key_pool[$urandom_range(0, pool_size - 1)] : $urandom;
                op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
                send_item(make_item(op, k, $urandom), quiet);
            end
            settle();
        end
        rsp_quiet = 1'b0;

        // Wait out the tail of the pipeline.
        repeat (8) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d get responses never arrived", board.pending());
            board.errors++;
        end

        $display("Run covered %0d gets (%0d hits, %0d misses) and %0d puts with %0d evictions,",
                 board.n_gets, board.n_hits, board.n_gets - board.n_hits,
                 board.n_puts, board.n_evicted);
        $display("over %0d capacity settings including 0, 1, 16 and values above the store size.",
                 cap_writes);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
